/* sv/nscp_pkg.sv */
`timescale 1ns / 1ps
// types, codes and character constants for the network setting command parser
// no dependencies; imported by network_setting_command_parser and its test bench
package nscp_pkg;

	localparam int LINE_MAX_DEF    = 40;
	localparam int ADDR_WINDOW_DEF = 19;
	localparam int MAC_WINDOW_DEF  = 29;

	localparam int POS_W  = 6;
	localparam int ACC_W  = 10;
	localparam int DATA_W = 48;

	typedef enum logic [3:0] {
		PH_WAIT_DASH = 4'd0,
		PH_NO_DASH   = 4'd1,
		PH_LETTER    = 4'd2,
		PH_SPACE     = 4'd3,
		PH_GAP       = 4'd4,
		PH_LEAD      = 4'd5,
		PH_DIGITS    = 4'd6,
		PH_STOPPED   = 4'd7,
		PH_REPORT    = 4'd8,
		PH_MALFORMED = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		CMD_HELP    = 3'd0,
		CMD_IP      = 3'd1,
		CMD_MAC     = 3'd2,
		CMD_SUBNET  = 3'd3,
		CMD_GATEWAY = 3'd4,
		CMD_PRINT   = 3'd5,
		CMD_NONE    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DASH   = 2'd1,
		ST_UNKNOWN   = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

	localparam logic [4:0] OFF_GATEWAY = 5'd0;
	localparam logic [4:0] OFF_SUBNET  = 5'd4;
	localparam logic [4:0] OFF_IP      = 5'd14;

	localparam logic [2:0] ADDR_TOKENS = 3'd4;
	localparam logic [2:0] MAC_TOKENS  = 3'd6;
	localparam logic [2:0] TOKEN_SAT   = 3'd7;
	localparam logic [1:0] TOKEN_CHARS = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_S     = 8'h73;

	typedef struct packed {
		phase_t           ph;
		logic [1:0]       cc;
		logic [ACC_W-1:0] acc;
		logic             neg;
		logic             dend;
	} tok_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// one character into the current token, atoi style
	function automatic tok_t feed(input tok_t t, input logic [7:0] c);
		tok_t             r;
		logic [ACC_W-1:0] d;
		r = t;
		d = ACC_W'(c - CH_ZERO);
		r.cc = t.cc + 2'd1;
		if (t.ph == PH_LEAD) begin
			if (!is_space(c)) begin
				r.ph = PH_DIGITS;
				if (c == CH_DASH || c == CH_PLUS) begin
					r.neg = (c == CH_DASH);
				end else if (is_digit(c)) begin
					r.acc = d;
				end else begin
					r.dend = 1'b1;
				end
			end
		end else if (!t.dend && is_digit(c)) begin
			r.acc = {t.acc[ACC_W-4:0], 3'b000} + {t.acc[ACC_W-2:0], 1'b0} + d;
		end else begin
			r.dend = 1'b1;
		end
		return r;
	endfunction

endpackage

/* sv/network_setting_command_parser.sv */
`timescale 1ns / 1ps
// network setting command parser: up to one character per cycle in, one result per line out
// uses nscp_pkg for phase, command and status codes and the token feed function
// a line end passes the input register and then the result register on its way to m_tvalid
// throughput: one character per cycle, except that a line end waits in the input register
// while the result register holds a result not yet taken; the parse state sets the rate
// reset: arst_n clears the parse state and both valid flags; the octet store is not cleared
module network_setting_command_parser
	import nscp_pkg::*;
#(
	parameter int LINE_MAX    = LINE_MAX_DEF,
	parameter int ADDR_WINDOW = ADDR_WINDOW_DEF,
	parameter int MAC_WINDOW  = MAC_WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] ch
	input  logic              s_tlast,  // line_end
	output logic              m_tvalid,
	input  logic              m_tready,
	// [1:0] status, [4:2] command, [5] store_write, [10:6] store_offset,
	// [18:11] octet_first, [26:19] octet_second, [34:27] octet_third,
	// [42:35] octet_fourth, [47:43] zero
	output logic [DATA_W-1:0] m_tdata
);

	localparam logic [6:0] ADDR_LIM = 7'(ADDR_WINDOW + 3);
	localparam logic [6:0] MAC_LIM  = 7'(MAC_WINDOW + 3);
	localparam logic [6:0] LINE_LIM = 7'(LINE_MAX - 1);

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       advance;

	// parse state
	phase_t           phase_q;
	cmd_t             cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [2:0]       cnt_q;
	tok_t             tok_q;
	logic [7:0]       store_q [4];

	// result register
	logic             out_valid_q;
	logic [DATA_W-1:0] out_data_q;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// next state
	phase_t           ph_n;
	cmd_t             cmd_n;
	logic [POS_W-1:0] pos_n;
	logic [2:0]       cnt_n;
	tok_t             tok_n;
	tok_t             tok_fresh;
	logic             stop;
	logic             byte_fin;
	logic             do_fin;
	logic             wr_en;
	logic [1:0]       wr_idx;
	logic [7:0]       wr_val;
	logic             is_mac;
	logic             is_addr;
	logic [7:0]       sep;
	logic [6:0]       pos_x;
	phase_t           ph_f;

	assign is_mac  = (cmd_q == CMD_MAC);
	assign is_addr = (cmd_q == CMD_IP) || (cmd_q == CMD_SUBNET) || (cmd_q == CMD_GATEWAY);
	assign sep     = is_mac ? CH_COLON : CH_DOT;
	assign pos_x   = {1'b0, pos_q};

	always_comb begin
		ph_n      = phase_q;
		cmd_n     = cmd_q;
		pos_n     = pos_q;
		cnt_n     = cnt_q;
		tok_n     = tok_q;
		stop      = 1'b0;
		byte_fin  = 1'b0;
		tok_fresh = '{ph: PH_LEAD, cc: 2'd0, acc: '0, neg: 1'b0, dend: 1'b0};
		case (phase_q)
			PH_WAIT_DASH: begin
				if (ch_s1 == CH_NUL) begin
					ph_n = PH_NO_DASH;
				end else if (ch_s1 == CH_DASH) begin
					ph_n  = PH_LETTER;
					pos_n = POS_W'(1);
				end
			end
			PH_LETTER: begin
				ph_n = PH_SPACE;
				case (ch_s1)
					CH_H: begin
						cmd_n = CMD_HELP;
						ph_n  = PH_REPORT;
					end
					CH_P: begin
						cmd_n = CMD_PRINT;
						ph_n  = PH_REPORT;
					end
					CH_I: cmd_n = CMD_IP;
					CH_S: cmd_n = CMD_SUBNET;
					CH_G: cmd_n = CMD_GATEWAY;
					CH_M: cmd_n = CMD_MAC;
					default: begin
						cmd_n = CMD_NONE;
						ph_n  = PH_REPORT;
					end
				endcase
				pos_n = pos_q + POS_W'(1);
			end
			PH_SPACE: begin
				ph_n  = (ch_s1 == CH_SPACE) ? PH_GAP : PH_MALFORMED;
				pos_n = pos_q + POS_W'(1);
			end
			PH_GAP, PH_LEAD, PH_DIGITS: begin
				// a zero byte, the window and the line length bound end the text
				if (ch_s1 == CH_NUL || pos_x < 7'd3 || pos_x >= (is_mac ? MAC_LIM : ADDR_LIM)
						|| pos_x >= LINE_LIM) begin
					stop     = 1'b1;
					byte_fin = 1'b1;
				end else if (is_addr && pos_x == 7'd3 && !is_digit(ch_s1)) begin
					ph_n = PH_MALFORMED;
				end else if (phase_q == PH_GAP) begin
					if (ch_s1 != sep) begin
						if (cnt_q != TOKEN_SAT) begin
							cnt_n = cnt_q + 3'd1;
						end
						tok_n = feed(tok_fresh, ch_s1);
						ph_n  = tok_n.ph;
					end
				end else if (ch_s1 == sep) begin
					byte_fin = 1'b1;
				end else if (tok_q.cc < TOKEN_CHARS) begin
					tok_n = feed(tok_q, ch_s1);
					ph_n  = tok_n.ph;
				end
				if (pos_q != {POS_W{1'b1}}) begin
					pos_n = pos_q + POS_W'(1);
				end
			end
			default: ;
		endcase

		// close the open token on a separator, a stop or the end of the line
		do_fin = (byte_fin || last_s1) && (ph_n == PH_LEAD || ph_n == PH_DIGITS);
		wr_en  = do_fin && is_addr && cnt_n >= 3'd1 && cnt_n <= ADDR_TOKENS;
		wr_idx = 2'(cnt_n - 3'd1);
		wr_val = tok_n.neg ? (8'd0 - tok_n.acc[7:0]) : tok_n.acc[7:0];
		if (stop) begin
			ph_f = PH_STOPPED;
		end else if (do_fin) begin
			ph_f = PH_GAP;
		end else begin
			ph_f = ph_n;
		end
		tok_n.ph = ph_f;
	end

	// result of a completed line
	status_t    res_status;
	cmd_t       res_cmd;
	logic       res_wr;
	logic [4:0] res_off;
	logic [7:0] oct [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			oct[k] = (wr_en && wr_idx == 2'(k)) ? wr_val : store_q[k];
		end
		res_status = ST_OK;
		res_cmd    = cmd_n;
		res_wr     = 1'b0;
		res_off    = OFF_GATEWAY;
		case (ph_f)
			PH_WAIT_DASH, PH_NO_DASH: begin
				res_status = ST_NO_DASH;
				res_cmd    = CMD_NONE;
			end
			PH_LETTER: begin
				res_status = ST_UNKNOWN;
				res_cmd    = CMD_NONE;
			end
			PH_REPORT: begin
				res_status = (cmd_n == CMD_NONE) ? ST_UNKNOWN : ST_OK;
			end
			PH_GAP, PH_STOPPED: begin
				if (cmd_n == CMD_MAC) begin
					res_status = (cnt_n == MAC_TOKENS) ? ST_OK : ST_MALFORMED;
				end else if (cnt_n == ADDR_TOKENS) begin
					res_wr = 1'b1;
					if (cmd_n == CMD_GATEWAY) begin
						res_off = OFF_GATEWAY;
					end else if (cmd_n == CMD_SUBNET) begin
						res_off = OFF_SUBNET;
					end else begin
						res_off = OFF_IP;
					end
				end else begin
					res_status = ST_MALFORMED;
				end
			end
			default: res_status = ST_MALFORMED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_DASH;
			cmd_q   <= CMD_NONE;
			pos_q   <= '0;
			cnt_q   <= '0;
			tok_q   <= '{ph: PH_WAIT_DASH, cc: 2'd0, acc: '0, neg: 1'b0, dend: 1'b0};
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_WAIT_DASH;
				cmd_q   <= CMD_NONE;
				pos_q   <= '0;
				cnt_q   <= '0;
				tok_q   <= '{ph: PH_WAIT_DASH, cc: 2'd0, acc: '0, neg: 1'b0, dend: 1'b0};
			end else begin
				phase_q <= ph_f;
				cmd_q   <= cmd_n;
				pos_q   <= pos_n;
				cnt_q   <= cnt_n;
				tok_q   <= tok_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			store_q[wr_idx] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= {5'd0,
				res_wr ? oct[3] : 8'd0,
				res_wr ? oct[2] : 8'd0,
				res_wr ? oct[1] : 8'd0,
				res_wr ? oct[0] : 8'd0,
				res_off, res_wr, res_cmd, res_status};
		end
	end

endmodule

/* test/network_setting_command_parser_test.sv */
`timescale 1ns / 1ps
// self-checking bench for network_setting_command_parser: typed command lines in, parse results out
// needs nscp_pkg and the parser rtl; a built-in line parser model predicts every result the script does not give
module network_setting_command_parser_test;
	import nscp_pkg::*;

	localparam int ARG_START    = 3;       // line position of the first argument character
	localparam int POS_SAT      = 63;
	localparam int IDLE_PCT     = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_CHARS = 240;
	localparam int SETTLE       = 10;
	localparam int CYCLE_LIMIT  = 200000;

	// same bit order as m_tdata[42:0]
	typedef struct packed {
		logic [7:0] oct4;
		logic [7:0] oct3;
		logic [7:0] oct2;
		logic [7:0] oct1;
		logic [4:0] store_offset;
		logic       store_write;
		cmd_t       command;
		status_t    status;
	} line_result_t;

	typedef struct packed {
		logic         typed;
		line_result_t want;
	} line_plan_t;

	typedef struct {
		string        text;
		int           swap_at;  // index replaced by swap_ch, -1 for none
		logic [7:0]   swap_ch;
		bit           typed;
		line_result_t want;
	} script_row_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = 8'h00;
	logic              s_tlast  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;

	network_setting_command_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// parser model state
	phase_t     ph     = PH_WAIT_DASH;
	cmd_t       letter = CMD_NONE;
	logic [5:0] pos    = '0;
	logic [2:0] ntok   = '0;
	logic [1:0] nch    = '0;
	logic [9:0] acc    = '0;
	logic       neg    = 1'b0;
	logic       dend   = 1'b0;
	logic [7:0] octets [4];

	line_result_t expect_q[$];
	line_plan_t   plan_q[$];
	logic [7:0]   text_q[$];
	script_row_t  script[$];

	int errors       = 0;
	int lines_sent   = 0;
	int results_seen = 0;
	int chars_sent   = 0;
	int n_writes     = 0;
	int n_mac_ok     = 0;
	int n_rejected   = 0;
	int idle_pct     = IDLE_PCT;
	int hold_left    = 0;
	int cycles       = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit is_num(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit addr_cmd();
		return letter == CMD_IP || letter == CMD_SUBNET || letter == CMD_GATEWAY;
	endfunction

	function automatic line_result_t verdict(input status_t st, input cmd_t cm, input logic wr,
			input logic [4:0] off, input logic [7:0] a, b, c, d);
		line_result_t r;
		r.status       = st;
		r.command      = cm;
		r.store_write  = wr;
		r.store_offset = off;
		r.oct1         = a;
		r.oct2         = b;
		r.oct3         = c;
		r.oct4         = d;
		return r;
	endfunction

	task automatic close_token();
		if (ph == PH_LEAD || ph == PH_DIGITS) begin
			if (addr_cmd() && ntok >= 3'd1 && ntok <= ADDR_TOKENS) begin
				octets[2'(ntok - 3'd1)] = neg ? 8'(-acc) : acc[7:0];
			end
			ph = PH_GAP;
		end
	endtask

	// atoi-style step on the current token
	task automatic take_char(input logic [7:0] c);
		nch = nch + 2'd1;
		if (ph == PH_LEAD) begin
			if (!is_blank(c)) begin
				ph = PH_DIGITS;
				if (c == CH_DASH || c == CH_PLUS) begin
					neg = (c == CH_DASH);
				end else if (is_num(c)) begin
					acc = 10'(c - CH_ZERO);
				end else begin
					dend = 1'b1;
				end
			end
		end else if (!dend && is_num(c)) begin
			acc = 10'(acc * 10 + (c - CH_ZERO));
		end else begin
			dend = 1'b1;
		end
	endtask

	task automatic arg_char(input logic [7:0] c);
		int         p;
		int         win;
		logic [7:0] sep;
		p   = pos;
		win = (letter == CMD_MAC) ? MAC_WINDOW_DEF : ADDR_WINDOW_DEF;
		sep = (letter == CMD_MAC) ? CH_COLON : CH_DOT;
		if (c == CH_NUL || p < ARG_START || p - ARG_START >= win || p + 1 >= LINE_MAX_DEF) begin
			close_token();
			ph = PH_STOPPED;
		end else if (addr_cmd() && p == ARG_START && !is_num(c)) begin
			ph = PH_MALFORMED;
		end else if (ph == PH_GAP) begin
			// separators between tokens are skipped, so empty tokens vanish
			if (c != sep) begin
				if (ntok < TOKEN_SAT) ntok = ntok + 3'd1;
				acc  = '0;
				neg  = 1'b0;
				dend = 1'b0;
				nch  = '0;
				ph   = PH_LEAD;
				take_char(c);
			end
		end else if (c == sep) begin
			close_token();
		end else if (nch < TOKEN_CHARS) begin
			take_char(c);
		end
	endtask

	task automatic parse_char(input logic [7:0] c, input logic last, output bit done,
			output line_result_t r);
		r    = '0;
		done = last;
		case (ph)
			PH_WAIT_DASH: begin
				if (c == CH_NUL) begin
					ph = PH_NO_DASH;
				end else if (c == CH_DASH) begin
					ph  = PH_LETTER;
					pos = 6'd1;
				end
			end
			PH_LETTER: begin
				ph = PH_SPACE;
				case (c)
					CH_H: begin
						letter = CMD_HELP;
						ph     = PH_REPORT;
					end
					CH_P: begin
						letter = CMD_PRINT;
						ph     = PH_REPORT;
					end
					CH_I: letter = CMD_IP;
					CH_S: letter = CMD_SUBNET;
					CH_G: letter = CMD_GATEWAY;
					CH_M: letter = CMD_MAC;
					default: begin
						letter = CMD_NONE;
						ph     = PH_REPORT;
					end
				endcase
				pos = pos + 6'd1;
			end
			PH_SPACE: begin
				ph  = (c == CH_SPACE) ? PH_GAP : PH_MALFORMED;
				pos = pos + 6'd1;
			end
			PH_GAP, PH_LEAD, PH_DIGITS: begin
				arg_char(c);
				if (pos < POS_SAT) pos = pos + 6'd1;
			end
			default: ;
		endcase
		if (last) begin
			close_token();
			r.command = letter;
			case (ph)
				PH_WAIT_DASH, PH_NO_DASH: begin
					r.status  = ST_NO_DASH;
					r.command = CMD_NONE;
				end
				PH_LETTER: begin
					r.status  = ST_UNKNOWN;
					r.command = CMD_NONE;
				end
				PH_REPORT: r.status = (letter == CMD_NONE) ? ST_UNKNOWN : ST_OK;
				PH_GAP, PH_STOPPED: begin
					if (letter == CMD_MAC) begin
						r.status = (ntok == MAC_TOKENS) ? ST_OK : ST_MALFORMED;
					end else if (ntok == ADDR_TOKENS) begin
						r.status       = ST_OK;
						r.store_write  = 1'b1;
						r.store_offset = (letter == CMD_GATEWAY) ? OFF_GATEWAY :
							(letter == CMD_SUBNET) ? OFF_SUBNET : OFF_IP;
						r.oct1 = octets[0];
						r.oct2 = octets[1];
						r.oct3 = octets[2];
						r.oct4 = octets[3];
					end else begin
						r.status = ST_MALFORMED;
					end
				end
				default: r.status = ST_MALFORMED;
			endcase
			ph     = PH_WAIT_DASH;
			letter = CMD_NONE;
			pos    = '0;
			ntok   = '0;
			nch    = '0;
			acc    = '0;
			neg    = 1'b0;
			dend   = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	// called right after a rising edge; returns at the edge that takes the request
	task automatic put_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_line(input bit typed, input line_result_t want);
		int k;
		plan_q.push_back('{typed, want});
		lines_sent++;
		for (k = 0; k < text_q.size(); k++) put_char(text_q[k], k == text_q.size() - 1);
		chars_sent += text_q.size();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (results_seen != lines_sent) @(posedge clk);
	endtask

	task automatic add_token(input bit first, input bit mac);
		string digits;
		int    roll;
		int    k;
		roll = $urandom_range(99);
		if (!first) begin
			if (roll < 8) text_q.push_back(roll < 4 ? CH_SPACE : CH_TAB);
			else if (roll < 16) text_q.push_back(roll < 12 ? CH_DASH : CH_PLUS);
		end
		if (mac) digits = $sformatf("%02x", $urandom_range(255));
		else digits = $sformatf("%0d", $urandom_range(roll >= 94 ? 9999 : 255));
		for (k = 0; k < digits.len(); k++) text_q.push_back(digits[k]);
	endtask

	// mostly well-formed commands with random values, some noise and damaged lines
	task automatic compose_line();
		int         pick;
		int         ntoks;
		int         k;
		bit         is_mac;
		logic [7:0] sep;
		text_q.delete();
		pick = $urandom_range(99);
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(8'h7A, 8'h61)));
		end
		if (pick < 15) begin
			repeat ($urandom_range(12, 1)) text_q.push_back(8'($urandom_range(255)));
		end else if (pick < 25) begin
			text_q.push_back(CH_DASH);
			text_q.push_back($urandom_range(1) ? CH_H : CH_P);
			if ($urandom_range(1)) begin
				repeat ($urandom_range(8, 1)) text_q.push_back(8'($urandom_range(126, 32)));
			end
		end else begin
			is_mac = (pick < 45);
			sep    = is_mac ? CH_COLON : CH_DOT;
			text_q.push_back(CH_DASH);
			if (is_mac) begin
				text_q.push_back(CH_M);
			end else begin
				case ($urandom_range(2))
					0: text_q.push_back(CH_I);
					1: text_q.push_back(CH_S);
					default: text_q.push_back(CH_G);
				endcase
			end
			text_q.push_back(CH_SPACE);
			ntoks = is_mac ? MAC_TOKENS : ADDR_TOKENS;
			if ($urandom_range(9) == 0) ntoks += $urandom_range(1) ? 1 : -1;
			for (k = 0; k < ntoks; k++) begin
				if (k > 0) begin
					text_q.push_back(sep);
					if ($urandom_range(9) == 0) text_q.push_back(sep);
				end
				add_token(k == 0, is_mac);
			end
			if (pick >= 85) text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
		end
	endtask

	// receiver: random back-pressure plus one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// checks results first, then takes the request of the same edge into the model
	initial begin
		line_result_t got;
		line_result_t want;
		line_result_t guess;
		line_plan_t   plan;
		bit           done;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = line_result_t'(m_tdata[42:0]);
				if (expect_q.size() == 0) begin
					errors++;
					$display("%0t: result %h arrived with nothing expected", $time, m_tdata);
				end else begin
					want = expect_q.pop_front();
					check_field("status", want.status, got.status);
					check_field("command", want.command, got.command);
					check_field("store_write", want.store_write, got.store_write);
					check_field("store_offset", want.store_offset, got.store_offset);
					check_field("octet_first", want.oct1, got.oct1);
					check_field("octet_second", want.oct2, got.oct2);
					check_field("octet_third", want.oct3, got.oct3);
					check_field("octet_fourth", want.oct4, got.oct4);
					check_field("pad bits", 0, m_tdata[DATA_W-1:43]);
					results_seen++;
					if (got.store_write) n_writes++;
					if (got.command == CMD_MAC && got.status == ST_OK) n_mac_ok++;
					if (got.status != ST_OK) n_rejected++;
				end
			end
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata, s_tlast, done, guess);
				if (done) begin
					plan = plan_q.pop_front();
					expect_q.push_back(plan.typed ? plan.want : guess);
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int k;
		int n;
		int random_chars;
		script = '{
			'{"x", -1, CH_NUL, 1, verdict(ST_NO_DASH, CMD_NONE, 0, 5'd0, 0, 0, 0, 0)},
			'{"ab?-h", 2, CH_NUL, 1, verdict(ST_NO_DASH, CMD_NONE, 0, 5'd0, 0, 0, 0, 0)},
			'{"?-h", 0, 8'hFF, 1, verdict(ST_OK, CMD_HELP, 0, 5'd0, 0, 0, 0, 0)},
			'{"-", -1, CH_NUL, 1, verdict(ST_UNKNOWN, CMD_NONE, 0, 5'd0, 0, 0, 0, 0)},
			'{"  -p", -1, CH_NUL, 1, verdict(ST_OK, CMD_PRINT, 0, 5'd0, 0, 0, 0, 0)},
			'{"-h extra text", -1, CH_NUL, 1, verdict(ST_OK, CMD_HELP, 0, 5'd0, 0, 0, 0, 0)},
			'{"-z", -1, CH_NUL, 1, verdict(ST_UNKNOWN, CMD_NONE, 0, 5'd0, 0, 0, 0, 0)},
			'{"--", -1, CH_NUL, 1, verdict(ST_UNKNOWN, CMD_NONE, 0, 5'd0, 0, 0, 0, 0)},
			'{"-i 192.168.1.1", -1, CH_NUL, 1,
				verdict(ST_OK, CMD_IP, 1, OFF_IP, 192, 168, 1, 1)},
			'{"-s 255.255.255.0", -1, CH_NUL, 1,
				verdict(ST_OK, CMD_SUBNET, 1, OFF_SUBNET, 255, 255, 255, 0)},
			'{"-g 0.0.0.0", -1, CH_NUL, 1,
				verdict(ST_OK, CMD_GATEWAY, 1, OFF_GATEWAY, 0, 0, 0, 0)},
			'{"-i 255.255.255.255", -1, CH_NUL, 1,
				verdict(ST_OK, CMD_IP, 1, OFF_IP, 255, 255, 255, 255)},
			'{"-i 1..2...3.4.", -1, CH_NUL, 1, verdict(ST_OK, CMD_IP, 1, OFF_IP, 1, 2, 3, 4)},
			'{"-g 9.-12.+7.999", -1, CH_NUL, 1,
				verdict(ST_OK, CMD_GATEWAY, 1, OFF_GATEWAY, 9, 244, 7, 231)},
			'{"-i 1.2.3", -1, CH_NUL, 1, verdict(ST_MALFORMED, CMD_IP, 0, 5'd0, 0, 0, 0, 0)},
			'{"-i 1.2.3.4.5", -1, CH_NUL, 1,
				verdict(ST_MALFORMED, CMD_IP, 0, 5'd0, 0, 0, 0, 0)},
			'{"-ix1.2.3.4", -1, CH_NUL, 1, verdict(ST_MALFORMED, CMD_IP, 0, 5'd0, 0, 0, 0, 0)},
			'{"-s a.2.3.4", -1, CH_NUL, 1,
				verdict(ST_MALFORMED, CMD_SUBNET, 0, 5'd0, 0, 0, 0, 0)},
			'{"-i", -1, CH_NUL, 1, verdict(ST_MALFORMED, CMD_IP, 0, 5'd0, 0, 0, 0, 0)},
			'{"-m 00:1a:22:33:44:55", -1, CH_NUL, 1,
				verdict(ST_OK, CMD_MAC, 0, 5'd0, 0, 0, 0, 0)},
			'{"-m 1:2:3", -1, CH_NUL, 1, verdict(ST_MALFORMED, CMD_MAC, 0, 5'd0, 0, 0, 0, 0)},
			'{"-m 1:2:3:4:5:6:7", -1, CH_NUL, 1,
				verdict(ST_MALFORMED, CMD_MAC, 0, 5'd0, 0, 0, 0, 0)},
			// zero byte ends the text, the junk after it is ignored
			'{"-i 1.2.3.4?junk", 10, CH_NUL, 1, verdict(ST_OK, CMD_IP, 1, OFF_IP, 1, 2, 3, 4)},
			// the 9 falls just past the address window
			'{"-i 1.2.3.4............9", -1, CH_NUL, 1,
				verdict(ST_OK, CMD_IP, 1, OFF_IP, 1, 2, 3, 4)},
			'{"-s 1. \t7.3.4", -1, CH_NUL, 0, '0},
			'{"-i 1234.5.6.7x", 13, 8'hFF, 0, '0}
		};
		random_chars = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			text_q.delete();
			for (k = 0; k < script[i].text.len(); k++) begin
				text_q.push_back(k == script[i].swap_at ? script[i].swap_ch : script[i].text[k]);
			end
			send_line(script[i].typed, script[i].want);
		end
		drain();

		n = 0;
		while (random_chars < RANDOM_CHARS) begin
			if (n == 2) hold_left = HOLD_CYCLES;
			if (n == 4) idle_pct = 0;
			if (n == 8) drain();
			if (n == 10) idle_pct = IDLE_PCT;
			compose_line();
			send_line(1'b0, '0);
			random_chars += text_q.size();
			n++;
		end
		drain();
		repeat (SETTLE) @(posedge clk);

		if (expect_q.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, expect_q.size());
		end
		$display("covered %0d command lines in %0d characters", lines_sent, chars_sent);
		$display("%0d settings writes, %0d mac lines accepted, %0d lines rejected",
			n_writes, n_mac_ok, n_rejected);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* network_setting_command_parser.f */
sv/nscp_pkg.sv
sv/network_setting_command_parser.sv
test/network_setting_command_parser_test.sv
